// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the console renderer RTL.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication under an active-low reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/tcgr_pkg.sv =====
// Constants and codes for the text console glyph renderer.
// No dependencies.
`timescale 1ns / 1ps

package tcgr_pkg;

    localparam int GLYPH_WIDTH  = 12;
    localparam int GLYPH_HEIGHT = 22;
    localparam int GLYPH_COUNT  = 256;
    localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);

    localparam int CODE_W    = 8;
    localparam int ROW_W     = 5;
    localparam int PATTERN_W = 12;
    localparam int COL_W     = 9;
    localparam int LINE_W    = 8;
    localparam int PIX_W     = 13;
    localparam int PITCH_W   = 13;
    localparam int ADDR_W    = 26;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PUT  = 1'b1;

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_CELL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_CELL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_WORDS  = 3'd4;

    localparam logic [COL_W-1:0]   LEFT_CELL_RST    = 9'd0;
    localparam logic [COL_W-1:0]   RIGHT_LIMIT_RST  = 9'd80;
    localparam logic [LINE_W-1:0]  TOP_CELL_RST     = 8'd0;
    localparam logic [LINE_W-1:0]  BOTTOM_LIMIT_RST = 8'd25;
    localparam logic [PITCH_W-1:0] PITCH_WORDS_RST  = 13'd1024;

    localparam logic [COL_W-1:0]  COL_MAX  = '1;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

endpackage

// ===== rtl/tcgr_item_if.sv =====
// Input channel: glyph loads and character puts.
// Depends on tcgr_pkg.
`timescale 1ns / 1ps

interface tcgr_item_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [tcgr_pkg::CODE_W-1:0]    code;
    logic [tcgr_pkg::ROW_W-1:0]     glyph_row;
    logic [tcgr_pkg::PATTERN_W-1:0] row_pattern;

    modport source (output valid, cmd, code, glyph_row, row_pattern, input ready);
    modport sink (input valid, cmd, code, glyph_row, row_pattern, output ready);
endinterface

// ===== rtl/tcgr_result_if.sv =====
// Output channel: one word per rendered glyph row.
// Depends on tcgr_pkg.
`timescale 1ns / 1ps

interface tcgr_result_if;
    logic                           valid;
    logic                           ready;
    logic [tcgr_pkg::PIX_W-1:0]     pixel_x;
    logic [tcgr_pkg::PIX_W-1:0]     pixel_y;
    logic [tcgr_pkg::ADDR_W-1:0]    word_address;
    logic [tcgr_pkg::PATTERN_W-1:0] row_bits;
    logic                           last_row;

    modport source (output valid, pixel_x, pixel_y, word_address, row_bits, last_row,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, word_address, row_bits, last_row,
                  output ready);
endinterface

// ===== rtl/tcgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcgr_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 5632
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/text_console_glyph_renderer.sv =====
// Text console glyph renderer: cursor, wrap/drop control and glyph row streamer.
// Depends on tcgr_pkg, tcgr_item_if, tcgr_result_if, tcgr_ram, assert_macros.svh.
//
//   port     dir   word
//   item     sink  cmd, code, glyph_row, row_pattern
//   result   src   pixel_x, pixel_y, word_address, row_bits, last_row
//   cfg_*    in    write enable, register index, data
//
// Loads and newlines complete on acceptance. A printed character goes through
// wrap, base coordinates or a drop at the bottom limit, base address multiply,
// then one row per cycle off the glyph RAM read port, with the address stepped by one pitch add.
// Result stalls hold the row stream; the last row may wait in the output
// register while the next word is taken. No clearing pass after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_glyph_renderer (
    input  logic                              clk,
    input  logic                              rst_n,
    tcgr_item_if.sink                         item,
    tcgr_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_RUN
    } state_t;

    state_t                              state_reg,  state_next;
    logic [tcgr_pkg::COL_W-1:0]          left_reg,   left_next;
    logic [tcgr_pkg::COL_W-1:0]          right_reg,  right_next;
    logic [tcgr_pkg::LINE_W-1:0]         top_reg,    top_next;
    logic [tcgr_pkg::LINE_W-1:0]         bottom_reg, bottom_next;
    logic [tcgr_pkg::PITCH_W-1:0]        pitch_reg,  pitch_next;
    logic [tcgr_pkg::COL_W-1:0]          col_reg,    col_next;
    logic [tcgr_pkg::LINE_W-1:0]         line_reg,   line_next;
    logic [tcgr_pkg::CODE_W-1:0]         code_reg,   code_next;
    logic [tcgr_pkg::PIX_W-1:0]          px_reg,     px_next;
    logic [tcgr_pkg::PIX_W-1:0]          py_reg,     py_next;
    logic [tcgr_pkg::ADDR_W-1:0]         addr_reg,   addr_next;
    logic [tcgr_pkg::STORE_AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [tcgr_pkg::ROW_W-1:0]          row_reg,    row_next;
    logic                                dv_reg,     dv_next;
    logic                                ov_reg,     ov_next;
    logic [tcgr_pkg::PIX_W-1:0]          o_px_reg,   o_px_next;
    logic [tcgr_pkg::PIX_W-1:0]          o_py_reg,   o_py_next;
    logic [tcgr_pkg::ADDR_W-1:0]         o_addr_reg, o_addr_next;
    logic [tcgr_pkg::PATTERN_W-1:0]      o_bits_reg, o_bits_next;
    logic                                o_last_reg, o_last_next;

    logic                                accept_in;
    logic                                consume;
    logic                                last;
    logic [tcgr_pkg::LINE_W-1:0]         line_inc;
    logic [tcgr_pkg::STORE_AW-1:0]       base_addr;
    logic [tcgr_pkg::STORE_AW-1:0]       ram_raddr;
    logic [tcgr_pkg::STORE_AW-1:0]       ram_waddr;
    logic                                ram_we;
    logic [tcgr_pkg::PATTERN_W-1:0]      ram_rdata;
    logic                                absent;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept_in  = item.valid && item.ready;
    assign consume    = (state_reg == ST_RUN) && dv_reg && (!ov_reg || result.ready);
    assign last       = (row_reg == tcgr_pkg::ROW_W'(tcgr_pkg::GLYPH_HEIGHT - 1));
    assign line_inc   = (line_reg != tcgr_pkg::LINE_MAX) ? line_reg + 1'b1 : line_reg;
    assign base_addr  = tcgr_pkg::STORE_AW'(code_reg)
                        * tcgr_pkg::STORE_AW'(tcgr_pkg::GLYPH_HEIGHT);
    assign absent     = (int'(code_reg) >= tcgr_pkg::GLYPH_COUNT);

    assign ram_we    = accept_in && (item.cmd == tcgr_pkg::CMD_LOAD)
                       && (int'(item.glyph_row) < tcgr_pkg::GLYPH_HEIGHT)
                       && (int'(item.code) < tcgr_pkg::GLYPH_COUNT);
    assign ram_waddr = tcgr_pkg::STORE_AW'(item.code)
                       * tcgr_pkg::STORE_AW'(tcgr_pkg::GLYPH_HEIGHT)
                       + tcgr_pkg::STORE_AW'(item.glyph_row);

    always_comb
    begin
        if (state_reg == ST_MUL)
        begin
            ram_raddr = base_addr;
        end
        else if (consume && !last)
        begin
            ram_raddr = rd_addr_reg + 1'b1;
        end
        else
        begin
            ram_raddr = rd_addr_reg;
        end
    end

    tcgr_ram #(
        .WIDTH (tcgr_pkg::PATTERN_W),
        .DEPTH (tcgr_pkg::STORE_DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.row_pattern),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        top_next     = top_reg;
        bottom_next  = bottom_reg;
        pitch_next   = pitch_reg;
        col_next     = col_reg;
        line_next    = line_reg;
        code_next    = code_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        addr_next    = addr_reg;
        rd_addr_next = rd_addr_reg;
        row_next     = row_reg;
        dv_next      = dv_reg;
        ov_next      = ov_reg && !result.ready;
        o_px_next    = o_px_reg;
        o_py_next    = o_py_reg;
        o_addr_next  = o_addr_reg;
        o_bits_next  = o_bits_reg;
        o_last_next  = o_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in && item.cmd == tcgr_pkg::CMD_PUT)
                begin
                    if (item.code == tcgr_pkg::NEWLINE_CODE)
                    begin
                        col_next  = left_reg;
                        line_next = line_inc;
                    end
                    else
                    begin
                        if (col_reg >= right_reg)
                        begin
                            col_next  = left_reg;
                            line_next = line_inc;
                        end
                        code_next  = item.code;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                if (line_reg >= bottom_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    px_next    = tcgr_pkg::PIX_W'(col_reg)
                                 * tcgr_pkg::PIX_W'(tcgr_pkg::GLYPH_WIDTH);
                    py_next    = tcgr_pkg::PIX_W'(line_reg)
                                 * tcgr_pkg::PIX_W'(tcgr_pkg::GLYPH_HEIGHT);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                addr_next    = tcgr_pkg::ADDR_W'(pitch_reg) * tcgr_pkg::ADDR_W'(py_reg)
                               + tcgr_pkg::ADDR_W'(px_reg);
                rd_addr_next = base_addr;
                row_next     = '0;
                dv_next      = 1'b1;
                state_next   = ST_RUN;
            end
            ST_RUN:
            begin
                if (consume)
                begin
                    ov_next     = 1'b1;
                    o_px_next   = px_reg;
                    o_py_next   = py_reg;
                    o_addr_next = addr_reg;
                    o_bits_next = absent ? '0 : ram_rdata;
                    o_last_next = last;
                    py_next     = py_reg + 1'b1;
                    addr_next   = addr_reg + tcgr_pkg::ADDR_W'(pitch_reg);
                    row_next    = row_reg + 1'b1;
                    if (last)
                    begin
                        dv_next    = 1'b0;
                        state_next = ST_IDLE;
                        if (col_reg != tcgr_pkg::COL_MAX)
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                tcgr_pkg::REG_LEFT_CELL:
                begin
                    left_next = cfg_data[tcgr_pkg::COL_W-1:0];
                    col_next  = cfg_data[tcgr_pkg::COL_W-1:0];
                end
                tcgr_pkg::REG_RIGHT_LIMIT:
                begin
                    right_next = cfg_data[tcgr_pkg::COL_W-1:0];
                end
                tcgr_pkg::REG_TOP_CELL:
                begin
                    top_next  = cfg_data[tcgr_pkg::LINE_W-1:0];
                    line_next = cfg_data[tcgr_pkg::LINE_W-1:0];
                end
                tcgr_pkg::REG_BOTTOM_LIMIT:
                begin
                    bottom_next = cfg_data[tcgr_pkg::LINE_W-1:0];
                end
                tcgr_pkg::REG_PITCH_WORDS:
                begin
                    pitch_next = cfg_data[tcgr_pkg::PITCH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            left_reg    <= tcgr_pkg::LEFT_CELL_RST;
            right_reg   <= tcgr_pkg::RIGHT_LIMIT_RST;
            top_reg     <= tcgr_pkg::TOP_CELL_RST;
            bottom_reg  <= tcgr_pkg::BOTTOM_LIMIT_RST;
            pitch_reg   <= tcgr_pkg::PITCH_WORDS_RST;
            col_reg     <= tcgr_pkg::LEFT_CELL_RST;
            line_reg    <= tcgr_pkg::TOP_CELL_RST;
            code_reg    <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
            addr_reg    <= '0;
            rd_addr_reg <= '0;
            row_reg     <= '0;
            dv_reg      <= 1'b0;
            ov_reg      <= 1'b0;
            o_px_reg    <= '0;
            o_py_reg    <= '0;
            o_addr_reg  <= '0;
            o_bits_reg  <= '0;
            o_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            top_reg     <= top_next;
            bottom_reg  <= bottom_next;
            pitch_reg   <= pitch_next;
            col_reg     <= col_next;
            line_reg    <= line_next;
            code_reg    <= code_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            addr_reg    <= addr_next;
            rd_addr_reg <= rd_addr_next;
            row_reg     <= row_next;
            dv_reg      <= dv_next;
            ov_reg      <= ov_next;
            o_px_reg    <= o_px_next;
            o_py_reg    <= o_py_next;
            o_addr_reg  <= o_addr_next;
            o_bits_reg  <= o_bits_next;
            o_last_reg  <= o_last_next;
        end
    end

    assign result.valid        = ov_reg;
    assign result.pixel_x      = o_px_reg;
    assign result.pixel_y      = o_py_reg;
    assign result.word_address = o_addr_reg;
    assign result.row_bits     = o_bits_reg;
    assign result.last_row     = o_last_reg;

    `ASSERT_IMPL(a_ready_no_fetch, clk, rst_n, item.ready, !dv_reg)
    `ASSERT_IMPL(a_fetch_in_run, clk, rst_n, dv_reg, state_reg == ST_RUN)
    `ASSERT_NEXT(a_last_to_idle, clk, rst_n, consume && last, state_reg == ST_IDLE && o_last_reg)
    `ASSERT_NEXT(a_prep_exit, clk, rst_n, state_reg == ST_PREP,
                 state_reg == ST_IDLE || state_reg == ST_MUL)
    `ASSERT_IMPL(a_row_bound, clk, rst_n, dv_reg,
                 int'(row_reg) < tcgr_pkg::GLYPH_HEIGHT)

endmodule
